@@ hw/rtl/escaped_frame_deframer_checksum_macros.svh @@
// Assertion macros for the escaped frame deframer.
`ifndef ESCAPED_FRAME_DEFRAMER_CHECKSUM_MACROS_SVH
`define ESCAPED_FRAME_DEFRAMER_CHECKSUM_MACROS_SVH

`ifndef SYNTH
// Check a property on the clock, ignoring cycles held in reset
`define EFDC_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check a property on the clock at every edge, reset included
`define EFDC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EFDC_ASSERT(label, clk, rstn, prop, msg)
`define EFDC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ hw/rtl/efdc_pkg.sv @@
// Package with constants and types of the escaped frame deframer.
`default_nettype none

package efdc_pkg;

  // Frame limits
  localparam int unsigned MAX_FRAME_BYTES = 2048;
  localparam logic [11:0] POS_MAX = 12'hFFF;
  localparam logic [11:0] PAY_LIMIT = (MAX_FRAME_BYTES < 4095) ?
                                      12'(MAX_FRAME_BYTES) : POS_MAX;
  localparam logic [11:0] PAYLOAD_START = 12'd11;
  localparam logic [11:0] MIN_FRAME_POS = 12'd12;

  // Framing and escape bytes
  localparam logic [7:0] ESC_BYTE = 8'hDB;
  localparam logic [7:0] ESC_END  = 8'hDC;
  localparam logic [7:0] ESC_ESC  = 8'hDD;
  localparam logic [7:0] END_MARK = 8'hC0;

  // Header positions
  localparam logic [11:0] POS_HEAD     = 12'd0;
  localparam logic [11:0] POS_VERSION  = 12'd1;
  localparam logic [11:0] POS_SENDER   = 12'd2;
  localparam logic [11:0] POS_RECEIVER = 12'd3;
  localparam logic [11:0] POS_LINK     = 12'd4;
  localparam logic [11:0] POS_OPER     = 12'd8;
  localparam logic [11:0] POS_OBJECT   = 12'd9;

  // Register indexes
  localparam logic [2:0] CFG_HEAD     = 3'd0;
  localparam logic [2:0] CFG_VERSION  = 3'd1;
  localparam logic [2:0] CFG_SENDER   = 3'd2;
  localparam logic [2:0] CFG_RECEIVER = 3'd3;
  localparam logic [2:0] CFG_TAIL     = 3'd4;

  // Register reset values
  localparam logic [7:0] RST_HEAD     = 8'hC0;
  localparam logic [7:0] RST_VERSION  = 8'h00;
  localparam logic [7:0] RST_SENDER   = 8'h00;
  localparam logic [7:0] RST_RECEIVER = 8'h00;
  localparam logic [7:0] RST_TAIL     = 8'hC0;

  // Result queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;
  localparam logic [QCNT_W-1:0] QMAX_FILL = 3'd1;

  typedef enum logic [1:0] {
    ST_OK              = 2'd0,
    ST_FRAME_WRONG     = 2'd1,
    ST_CHECKSUM_FAILED = 2'd2
  } status_e;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  payload_byte;
    status_e     status_code;
    logic [7:0]  link_code;
    logic [7:0]  object_code;
    logic [7:0]  operation_kind;
    logic [11:0] payload_total;
    logic        last_result;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/escaped_frame_deframer_checksum.sv @@
// Escaped frame deframer with 8-bit sum checksum and result queue.
// Results are written to the result queue on the accepted beat and leave it in order.
// Throughput: one input beat per cycle while the four-entry result queue holds
// at most one result; the results of one input leave the queue one per output transfer.
// Reset: asynchronous, active low; clears frame state, queue and loads the
// register defaults (head and tail C0, version and ids 00).
`default_nettype none
`include "escaped_frame_deframer_checksum_macros.svh"

module escaped_frame_deframer_checksum
  import efdc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        end_of_datagram_i,
  // Output channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             is_status_o,
  output logic [7:0]       payload_byte_o,
  output logic [1:0]       status_code_o,
  output logic [7:0]       link_code_o,
  output logic [7:0]       object_code_o,
  output logic [7:0]       operation_kind_o,
  output logic [11:0]      payload_total_o,
  output logic             last_result_o
);

  // Configuration registers
  logic [7:0] head_q, version_q, sender_q, receiver_q, tail_q;

  // Frame state
  logic [11:0] pos_q, pos_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  dly0_q, dly1_q;
  logic        hdr_q, hdr_d;
  logic [7:0]  link_q, link_d, obj_q, obj_d, oper_q, oper_d;
  logic        pend_q, pend_d;
  logic [11:0] pay_q;

  // Result queue
  result_t           queue_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  logic in_acc, out_acc, cfg_wr;

  // Datapath intermediates
  logic        escaped, do_conf, do_unesc;
  logic [11:0] conf_pos;
  logic        want_a, want_b, want_f;
  logic [7:0]  a_byte, received;
  logic        ok_a, ok_b, ok_f;
  logic [11:0] cnt1, cnt2, cnt3;
  status_e     code;
  result_t     cand [4];
  logic [3:0]  cand_v;
  logic [1:0]  off [4];
  logic [1:0]  n_res;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign cfg_wr  = psel && penable && pwrite && pready;

  // APB access: always ready, reads decode the register index
  assign pready = 1'b1;
  always_comb begin
    case (paddr[4:2])
      CFG_HEAD:     prdata = {24'd0, head_q};
      CFG_VERSION:  prdata = {24'd0, version_q};
      CFG_SENDER:   prdata = {24'd0, sender_q};
      CFG_RECEIVER: prdata = {24'd0, receiver_q};
      CFG_TAIL:     prdata = {24'd0, tail_q};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= RST_HEAD;
      version_q  <= RST_VERSION;
      sender_q   <= RST_SENDER;
      receiver_q <= RST_RECEIVER;
      tail_q     <= RST_TAIL;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        CFG_HEAD:     head_q     <= pwdata[7:0];
        CFG_VERSION:  version_q  <= pwdata[7:0];
        CFG_SENDER:   sender_q   <= pwdata[7:0];
        CFG_RECEIVER: receiver_q <= pwdata[7:0];
        CFG_TAIL:     tail_q     <= pwdata[7:0];
        default:      ;
      endcase
    end
  end

  // Header checks and captures for the incoming byte
  always_comb begin
    hdr_d = hdr_q;
    if ((pos_q == POS_HEAD && rx_byte_i != head_q) ||
        (pos_q == POS_VERSION && rx_byte_i != version_q) ||
        (pos_q == POS_SENDER && rx_byte_i != sender_q) ||
        (pos_q == POS_RECEIVER && rx_byte_i != receiver_q)) begin
      hdr_d = 1'b0;
    end
    link_d = (pos_q == POS_LINK)   ? rx_byte_i : link_q;
    oper_d = (pos_q == POS_OPER)   ? rx_byte_i : oper_q;
    obj_d  = (pos_q == POS_OBJECT) ? rx_byte_i : obj_q;
    pos_d  = (pos_q == POS_MAX) ? pos_q : pos_q + 12'd1;
  end

  // Confirm the byte two beats back as data: sum it, unescape payload
  always_comb begin
    escaped  = end_of_datagram_i && (pos_q >= 12'd2) && (dly1_q == ESC_BYTE) &&
               (dly0_q == ESC_END || dly0_q == ESC_ESC);
    do_conf  = (pos_q >= 12'd2) && !escaped;
    conf_pos = pos_q - 12'd2;
    sum_d    = (do_conf && conf_pos >= 12'd1) ? sum_q + dly1_q : sum_q;
    do_unesc = do_conf && (conf_pos >= PAYLOAD_START);

    want_a = 1'b0;
    want_b = 1'b0;
    a_byte = ESC_BYTE;
    pend_d = pend_q;
    if (do_unesc) begin
      if (pend_q) begin
        pend_d = 1'b0;
        want_a = 1'b1;
        if (dly1_q == ESC_END) begin
          a_byte = END_MARK;
        end
        if (dly1_q != ESC_END && dly1_q != ESC_ESC) begin
          if (dly1_q == ESC_BYTE) begin
            pend_d = 1'b1;
          end else begin
            want_b = 1'b1;
          end
        end
      end else if (dly1_q == ESC_BYTE) begin
        pend_d = 1'b1;
      end else begin
        want_b = 1'b1;
      end
    end
    // Flush a lone escape at the end of the frame
    want_f = end_of_datagram_i && pend_d;

    // Saturating payload count
    ok_a = want_a && (pay_q < PAY_LIMIT);
    cnt1 = pay_q + 12'(ok_a);
    ok_b = want_b && (cnt1 < PAY_LIMIT);
    cnt2 = cnt1 + 12'(ok_b);
    ok_f = want_f && (cnt2 < PAY_LIMIT);
    cnt3 = cnt2 + 12'(ok_f);
  end

  // End-of-frame status
  always_comb begin
    if (escaped) begin
      received = (dly0_q == ESC_END) ? END_MARK : ESC_BYTE;
    end else begin
      received = dly0_q;
    end
    if (!hdr_d || pos_q < MIN_FRAME_POS || rx_byte_i != tail_q) begin
      code = ST_FRAME_WRONG;
    end else if (sum_d != received) begin
      code = ST_CHECKSUM_FAILED;
    end else begin
      code = ST_OK;
    end
  end

  // Build candidate results and their queue offsets
  always_comb begin
    cand_v = {end_of_datagram_i, ok_f, ok_b, ok_a};
    off[0] = 2'd0;
    off[1] = {1'b0, cand_v[0]};
    off[2] = off[1] + {1'b0, cand_v[1]};
    off[3] = off[2] + {1'b0, cand_v[2]};
    n_res  = off[3] + {1'b0, cand_v[3]};

    cand[0] = '{is_status: 1'b0, payload_byte: a_byte, status_code: ST_OK,
                link_code: 8'd0, object_code: 8'd0, operation_kind: 8'd0,
                payload_total: cnt1, last_result: ~|cand_v[3:1]};
    cand[1] = '{is_status: 1'b0, payload_byte: dly1_q, status_code: ST_OK,
                link_code: 8'd0, object_code: 8'd0, operation_kind: 8'd0,
                payload_total: cnt2, last_result: ~|cand_v[3:2]};
    cand[2] = '{is_status: 1'b0, payload_byte: ESC_BYTE, status_code: ST_OK,
                link_code: 8'd0, object_code: 8'd0, operation_kind: 8'd0,
                payload_total: cnt3, last_result: ~cand_v[3]};
    cand[3] = '{is_status: 1'b1, payload_byte: 8'd0, status_code: code,
                link_code: link_d, object_code: obj_d, operation_kind: oper_d,
                payload_total: cnt3, last_result: 1'b1};
  end

  // Advance or clear the frame state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sum_q  <= '0;
      dly0_q <= '0;
      dly1_q <= '0;
      hdr_q  <= 1'b1;
      link_q <= '0;
      obj_q  <= '0;
      oper_q <= '0;
      pend_q <= 1'b0;
      pay_q  <= '0;
    end else if (in_acc) begin
      if (end_of_datagram_i) begin
        pos_q  <= '0;
        sum_q  <= '0;
        dly0_q <= '0;
        dly1_q <= '0;
        hdr_q  <= 1'b1;
        link_q <= '0;
        obj_q  <= '0;
        oper_q <= '0;
        pend_q <= 1'b0;
        pay_q  <= '0;
      end else begin
        pos_q  <= pos_d;
        sum_q  <= sum_d;
        dly0_q <= rx_byte_i;
        dly1_q <= dly0_q;
        hdr_q  <= hdr_d;
        link_q <= link_d;
        obj_q  <= obj_d;
        oper_q <= oper_d;
        pend_q <= pend_d;
        pay_q  <= cnt2;
      end
    end
  end

  // Push results into the queue
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      if (in_acc && cand_v[k]) begin
        queue_q[wr_q + off[k]] <= cand[k];
      end
    end
  end

  // Queue pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (in_acc) begin
        wr_q <= wr_q + n_res;
      end
      if (out_acc) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + (in_acc ? {1'b0, n_res} : 3'd0) - (out_acc ? 3'd1 : 3'd0);
    end
  end

  // Take a beat only when three free entries remain
  assign in_ready_o  = (cnt_q <= QMAX_FILL);
  assign out_valid_o = (cnt_q != '0);

  // Drive the head of the queue
  assign is_status_o      = queue_q[rd_q].is_status;
  assign payload_byte_o   = queue_q[rd_q].payload_byte;
  assign status_code_o    = queue_q[rd_q].status_code;
  assign link_code_o      = queue_q[rd_q].link_code;
  assign object_code_o    = queue_q[rd_q].object_code;
  assign operation_kind_o = queue_q[rd_q].operation_kind;
  assign payload_total_o  = queue_q[rd_q].payload_total;
  assign last_result_o    = queue_q[rd_q].last_result;

  // Checks
  `EFDC_ASSERT_ALWAYS(a_queue_fill, clk_i, !rst_ni || cnt_q <= QCNT_W'(QDEPTH), "result queue overfilled")
  `EFDC_ASSERT(a_pay_limit, clk_i, rst_ni, pay_q <= PAY_LIMIT, "payload count past limit")
  `EFDC_ASSERT(a_eod_clears, clk_i, rst_ni, (in_acc && end_of_datagram_i) |=> (pos_q == '0 && pay_q == '0 && !pend_q), "frame state not cleared after status")
  `EFDC_ASSERT(a_status_last, clk_i, rst_ni, (out_valid_o && is_status_o) |-> last_result_o, "status result not marked last")

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Testbench for the escaped frame deframer: sends frames, predicts and checks every result.
`timescale 1ns / 100ps

module tb_top;
  import efdc_pkg::*;

  // Clock, reset and block ports
  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = '0;
  logic        rx_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        is_status;
  logic [7:0]  payload_byte;
  logic [1:0]  status_code;
  logic [7:0]  link_code;
  logic [7:0]  object_code;
  logic [7:0]  operation_kind;
  logic [11:0] payload_total;
  logic        last_result;

  escaped_frame_deframer_checksum uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .rx_byte_i         (rx_byte),
    .end_of_datagram_i (rx_last),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .is_status_o       (is_status),
    .payload_byte_o    (payload_byte),
    .status_code_o     (status_code),
    .link_code_o       (link_code),
    .object_code_o     (object_code),
    .operation_kind_o  (operation_kind),
    .payload_total_o   (payload_total),
    .last_result_o     (last_result)
  );

  // Predicted deframer state and register copies
  logic [7:0]  cfg_q [0:4];
  logic [11:0] frame_pos;
  logic [7:0]  data_sum;
  logic [7:0]  lag_bytes [0:1];
  logic        header_ok;
  logic [7:0]  link_seen;
  logic [7:0]  object_seen;
  logic [7:0]  oper_seen;
  logic        esc_open;
  logic [11:0] payload_cnt;

  // Expected results, oldest first; the newest result of a beat is held back
  result_t     pending_results [$];
  result_t     staged_result;
  logic        staged_vld;

  // Stimulus controls
  logic [7:0]  frame_q [$];
  bit          tx_gaps_on;
  bit          steady_phase;
  int unsigned sink_hold_left;
  int unsigned beats_sent;
  int unsigned fault_cnt;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin : watchdog
    #20_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic log_fault(input string msg);
    fault_cnt++;
    if (fault_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------
  function automatic void restart_frame();
    frame_pos    = '0;
    data_sum     = '0;
    lag_bytes[0] = '0;
    lag_bytes[1] = '0;
    header_ok    = 1'b1;
    link_seen    = '0;
    object_seen  = '0;
    oper_seen    = '0;
    esc_open     = 1'b0;
    payload_cnt  = '0;
  endfunction

  function automatic void stage_result(input result_t r);
    if (staged_vld) pending_results.push_back(staged_result);
    staged_result = r;
    staged_vld    = 1'b1;
  endfunction

  function automatic void emit_payload(input logic [7:0] b);
    result_t r;
    // drop payload once the count has hit the limit
    if (payload_cnt >= PAY_LIMIT) return;
    payload_cnt     = payload_cnt + 12'd1;
    r               = '0;
    r.payload_byte  = b;
    r.payload_total = payload_cnt;
    stage_result(r);
  endfunction

  function automatic void unescape_byte(input logic [7:0] b);
    if (esc_open) begin
      esc_open = 1'b0;
      if (b == ESC_END) begin
        emit_payload(END_MARK);
        return;
      end
      if (b == ESC_ESC) begin
        emit_payload(ESC_BYTE);
        return;
      end
      // lone escape: pass it through as a plain DB
      emit_payload(ESC_BYTE);
    end
    if (b == ESC_BYTE) esc_open = 1'b1;
    else emit_payload(b);
  endfunction

  // Byte b at position p is now known to be data
  function automatic void confirm_data(input logic [7:0] b, input logic [11:0] p);
    if (p >= POS_VERSION) data_sum = data_sum + b;
    if (p >= PAYLOAD_START) unescape_byte(b);
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, input logic eod);
    logic [11:0] pos;
    logic [7:0]  cks_val;
    logic        escaped;
    status_e     code;
    result_t     r;
    pos = frame_pos;
    if (pos == POS_HEAD && b != cfg_q[CFG_HEAD]) header_ok = 1'b0;
    if (pos == POS_VERSION && b != cfg_q[CFG_VERSION]) header_ok = 1'b0;
    if (pos == POS_SENDER && b != cfg_q[CFG_SENDER]) header_ok = 1'b0;
    if (pos == POS_RECEIVER && b != cfg_q[CFG_RECEIVER]) header_ok = 1'b0;
    if (pos == POS_LINK) link_seen = b;
    if (pos == POS_OPER) oper_seen = b;
    if (pos == POS_OBJECT) object_seen = b;
    if (!eod) begin
      if (pos >= 12'd2) confirm_data(lag_bytes[1], pos - 12'd2);
      lag_bytes[1] = lag_bytes[0];
      lag_bytes[0] = b;
      if (pos < POS_MAX) frame_pos = pos + 12'd1;
    end else begin
      // the checksum is either an escape pair or one plain byte
      escaped = (pos >= 12'd2) && (lag_bytes[1] == ESC_BYTE) &&
                (lag_bytes[0] == ESC_END || lag_bytes[0] == ESC_ESC);
      if (escaped) begin
        cks_val = (lag_bytes[0] == ESC_END) ? END_MARK : ESC_BYTE;
      end else begin
        cks_val = lag_bytes[0];
        if (pos >= 12'd2) confirm_data(lag_bytes[1], pos - 12'd2);
      end
      // flush an escape left open at the end of the data
      if (esc_open) begin
        esc_open = 1'b0;
        emit_payload(ESC_BYTE);
      end
      if (!header_ok || pos < MIN_FRAME_POS || b != cfg_q[CFG_TAIL]) code = ST_FRAME_WRONG;
      else if (data_sum != cks_val) code = ST_CHECKSUM_FAILED;
      else code = ST_OK;
      r                = '0;
      r.is_status      = 1'b1;
      r.status_code    = code;
      r.link_code      = link_seen;
      r.object_code    = object_seen;
      r.operation_kind = oper_seen;
      r.payload_total  = payload_cnt;
      stage_result(r);
      restart_frame();
    end
    // mark the last result of this beat
    if (staged_vld) begin
      staged_result.last_result = 1'b1;
      pending_results.push_back(staged_result);
      staged_vld = 1'b0;
    end
  endfunction

  // ------------------------------------------------------------------
  // Result checker
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && out_valid && out_ready) begin
      got.is_status      = is_status;
      got.payload_byte   = payload_byte;
      got.status_code    = status_e'(status_code);
      got.link_code      = link_code;
      got.object_code    = object_code;
      got.operation_kind = operation_kind;
      got.payload_total  = payload_total;
      got.last_result    = last_result;
      if (pending_results.size() == 0) begin
        log_fault($sformatf("unexpected result st=%0b byte=%h code=%0d total=%0d",
                            got.is_status, got.payload_byte, got.status_code,
                            got.payload_total));
      end else begin
        want = pending_results.pop_front();
        if (got.is_status !== want.is_status || got.payload_byte !== want.payload_byte ||
            got.status_code !== want.status_code || got.link_code !== want.link_code ||
            got.object_code !== want.object_code ||
            got.operation_kind !== want.operation_kind ||
            got.payload_total !== want.payload_total ||
            got.last_result !== want.last_result) begin
          log_fault($sformatf({"result mismatch: expected st=%0b byte=%h code=%0d link=%h ",
                               "obj=%h op=%h total=%0d last=%0b, got st=%0b byte=%h ",
                               "code=%0d link=%h obj=%h op=%h total=%0d last=%0b"},
                              want.is_status, want.payload_byte, want.status_code,
                              want.link_code, want.object_code, want.operation_kind,
                              want.payload_total, want.last_result,
                              got.is_status, got.payload_byte, got.status_code,
                              got.link_code, got.object_code, got.operation_kind,
                              got.payload_total, got.last_result));
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Result sink with random stalls and long hold-offs
  // ------------------------------------------------------------------
  initial begin : result_sink
    int unsigned gap_left;
    int unsigned mode_left;
    bit          stalls_on;
    gap_left  = 0;
    mode_left = 0;
    stalls_on = 1'b1;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        stalls_on = ($urandom_range(0, 2) != 0);
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      if (sink_hold_left > 0) begin
        out_ready <= 1'b0;
        sink_hold_left--;
      end else if (gap_left > 0) begin
        out_ready <= 1'b0;
        gap_left--;
      end else if (stalls_on && !steady_phase && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        gap_left = $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------
  // Sender and register access
  // ------------------------------------------------------------------
  // Offer one beat and hold it until accepted; called and returns at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic eod);
    if (tx_gaps_on && !steady_phase && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    rx_last  <= eod;
    do @(posedge clk_i); while (!in_ready);
    deframe_byte(b, eod);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic tx_frame();
    int unsigned n;
    n = frame_q.size();
    for (int unsigned i = 0; i < n; i++) push_byte(frame_q[i], i == n - 1);
  endtask

  // Idle the input, wait for every expected result, then let the pipe settle
  task automatic wait_results_drained();
    int unsigned waited;
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cfg_q[idx] = val;
    @(negedge clk_i);
  endtask

  task automatic reg_read_check(input logic [2:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {24'h0, cfg_q[idx]})
      log_fault($sformatf("register %0d read %h, expected %h", idx, prdata, cfg_q[idx]));
    @(negedge clk_i);
  endtask

  task automatic read_all_regs();
    reg_read_check(CFG_HEAD);
    reg_read_check(CFG_VERSION);
    reg_read_check(CFG_SENDER);
    reg_read_check(CFG_RECEIVER);
    reg_read_check(CFG_TAIL);
  endtask

  // Program all registers and read them back; block must be idle
  task automatic set_regs(input logic [7:0] head, input logic [7:0] ver,
                          input logic [7:0] snd, input logic [7:0] rcv,
                          input logic [7:0] tail);
    reg_write(CFG_HEAD, head);
    reg_write(CFG_VERSION, ver);
    reg_write(CFG_SENDER, snd);
    reg_write(CFG_RECEIVER, rcv);
    reg_write(CFG_TAIL, tail);
    read_all_regs();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // ------------------------------------------------------------------
  // Frame building
  // ------------------------------------------------------------------
  function automatic logic [7:0] raw_sum();
    logic [7:0] s;
    s = '0;
    for (int i = 1; i < frame_q.size(); i++) s = s + frame_q[i];
    return s;
  endfunction

  // Header, bytes 4..10 and pay_len payload bytes, esc_pct percent as escape pairs
  function automatic void build_frame(input int unsigned pay_len, input int unsigned esc_pct);
    int unsigned made;
    frame_q.delete();
    frame_q.push_back(cfg_q[CFG_HEAD]);
    frame_q.push_back(cfg_q[CFG_VERSION]);
    frame_q.push_back(cfg_q[CFG_SENDER]);
    frame_q.push_back(cfg_q[CFG_RECEIVER]);
    repeat (7) frame_q.push_back(8'($urandom));
    made = 0;
    while (made < pay_len) begin
      if ($urandom_range(0, 99) < esc_pct) begin
        frame_q.push_back(ESC_BYTE);
        frame_q.push_back($urandom_range(0, 1) ? ESC_END : ESC_ESC);
      end else begin
        frame_q.push_back(8'($urandom));
      end
      made++;
    end
  endfunction

  // Append a data byte that makes the running sum hit target
  function automatic void steer_sum(input logic [7:0] target);
    frame_q.push_back(target - raw_sum());
  endfunction

  // Append the encoded checksum and the tail
  function automatic void close_frame();
    logic [7:0] s;
    s = raw_sum();
    if (s == END_MARK) begin
      frame_q.push_back(ESC_BYTE);
      frame_q.push_back(ESC_END);
    end else if (s == ESC_BYTE) begin
      frame_q.push_back(ESC_BYTE);
      frame_q.push_back(ESC_ESC);
    end else begin
      frame_q.push_back(s);
    end
    frame_q.push_back(cfg_q[CFG_TAIL]);
  endfunction

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  task automatic test_register_access();
    read_all_regs();
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic test_good_frames();
    tx_gaps_on = 1'b1;
    // minimal frame with no payload
    build_frame(0, 0);
    close_frame();
    tx_frame();
    // payload with escape pairs
    build_frame(8, 40);
    close_frame();
    tx_frame();
    // checksum C0 sent as an escape pair
    build_frame(4, 0);
    steer_sum(END_MARK);
    close_frame();
    tx_frame();
    // checksum DB sent as an escape pair
    build_frame(4, 0);
    steer_sum(ESC_BYTE);
    close_frame();
    tx_frame();
    wait_results_drained();
  endtask

  task automatic test_header_errors();
    // bad head, version, sender, receiver
    for (int i = 0; i < 4; i++) begin
      build_frame(3, 0);
      close_frame();
      frame_q[i] = frame_q[i] ^ 8'h01;
      tx_frame();
    end
    // bad tail
    build_frame(3, 0);
    close_frame();
    frame_q[frame_q.size() - 1] = frame_q[frame_q.size() - 1] ^ 8'h80;
    tx_frame();
    // twelve-byte frame
    build_frame(0, 0);
    close_frame();
    void'(frame_q.pop_back());
    void'(frame_q.pop_back());
    frame_q.push_back(cfg_q[CFG_TAIL]);
    tx_frame();
    // one-byte frame
    push_byte(cfg_q[CFG_HEAD], 1'b1);
    // bad tail together with a bad checksum: framing error wins
    build_frame(2, 0);
    close_frame();
    frame_q[5] = frame_q[5] ^ 8'h01;
    frame_q[frame_q.size() - 1] = ~frame_q[frame_q.size() - 1];
    tx_frame();
    wait_results_drained();
  endtask

  task automatic test_checksum_errors();
    build_frame(5, 20);
    close_frame();
    frame_q[5] = frame_q[5] ^ 8'h01;
    tx_frame();
    // wrong sum against an escaped checksum
    build_frame(3, 0);
    steer_sum(END_MARK);
    close_frame();
    frame_q[6] = frame_q[6] ^ 8'h01;
    tx_frame();
    wait_results_drained();
  endtask

  task automatic test_escape_edges();
    // lone escape, escaped escape, escaped end mark
    build_frame(0, 0);
    frame_q.push_back(ESC_BYTE);
    frame_q.push_back(8'h41);
    frame_q.push_back(ESC_BYTE);
    frame_q.push_back(ESC_BYTE);
    frame_q.push_back(ESC_ESC);
    frame_q.push_back(ESC_BYTE);
    frame_q.push_back(ESC_END);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'h00);
    close_frame();
    tx_frame();
    // escape as the last data byte
    build_frame(2, 0);
    frame_q.push_back(ESC_BYTE);
    close_frame();
    tx_frame();
    // escape pair as the last data bytes
    build_frame(1, 0);
    frame_q.push_back(ESC_BYTE);
    frame_q.push_back(ESC_ESC);
    close_frame();
    tx_frame();
    wait_results_drained();
  endtask

  // Hold off the sink so the block fills and stalls its input
  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    @(posedge clk_i);
    sink_hold_left = 150;
    @(negedge clk_i);
    build_frame(20, 10);
    close_frame();
    tx_frame();
    build_frame(12, 30);
    close_frame();
    tx_frame();
    wait_results_drained();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_frames(input int unsigned n_beats);
    int unsigned start;
    int unsigned pick;
    int unsigned keep;
    int unsigned idx;
    start = beats_sent;
    while (beats_sent - start < n_beats) begin
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 90) begin
        build_frame(($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) :
                    $urandom_range(0, 12), $urandom_range(0, 40));
        close_frame();
        if (pick >= 78) begin
          // break a well-formed frame
          case ($urandom_range(0, 3))
            0: begin
              idx = $urandom_range(0, 3);
              frame_q[idx] = frame_q[idx] ^ 8'($urandom_range(1, 255));
            end
            1: begin
              idx = frame_q.size() - 1;
              frame_q[idx] = frame_q[idx] ^ 8'($urandom_range(1, 255));
            end
            2: begin
              idx = $urandom_range(4, frame_q.size() - 2);
              frame_q[idx] = frame_q[idx] ^ 8'($urandom_range(1, 255));
            end
            default: begin
              keep = $urandom_range(1, 12);
              while (frame_q.size() > keep) void'(frame_q.pop_back());
              frame_q.push_back(cfg_q[CFG_TAIL]);
            end
          endcase
        end
      end else begin
        // noise
        frame_q.delete();
        repeat ($urandom_range(1, 24)) frame_q.push_back(8'($urandom));
      end
      tx_frame();
    end
    wait_results_drained();
  endtask

  task automatic test_register_settings();
    set_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    test_random_frames(20);
    set_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    test_random_frames(20);
    set_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    test_random_frames(20);
    set_regs(ESC_BYTE, 8'h01, 8'hA5, 8'h5A, ESC_BYTE);
    test_random_frames(15);
  endtask

  // Final stretch with no idling on either side
  task automatic test_steady_stream();
    set_regs(RST_HEAD, 8'($urandom), 8'($urandom), 8'($urandom), RST_TAIL);
    steady_phase = 1'b1;
    test_random_frames(45);
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin : test_sequence
    cfg_q[CFG_HEAD]     = RST_HEAD;
    cfg_q[CFG_VERSION]  = RST_VERSION;
    cfg_q[CFG_SENDER]   = RST_SENDER;
    cfg_q[CFG_RECEIVER] = RST_RECEIVER;
    cfg_q[CFG_TAIL]     = RST_TAIL;
    restart_frame();
    staged_vld     = 1'b0;
    tx_gaps_on     = 1'b1;
    steady_phase   = 1'b0;
    sink_hold_left = 0;
    beats_sent     = 0;
    fault_cnt      = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_register_access();
    test_good_frames();
    test_header_errors();
    test_checksum_errors();
    test_escape_edges();
    test_backpressure();
    test_register_settings();
    test_steady_stream();
    wait_results_drained();
    if (fault_cnt == 0 && pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
